### src/lucas_lehmer_mersenne_test_unit_assert.svh
// Assertion macros for the Lucas-Lehmer test unit.
// Each macro names a label, an antecedent, a consequent and a message.
// The enclosing module provides clk and rst_n.
`ifndef LUCAS_LEHMER_MERSENNE_TEST_UNIT_ASSERT_SVH
`define LUCAS_LEHMER_MERSENNE_TEST_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication
`define LLMT_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication
`define LLMT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define LLMT_ASSERT_NOW(label, ante, cons, msg)
`define LLMT_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

### src/llmt_pkg.sv
`default_nettype none

package llmt_pkg;

  // Default largest exponent that is tested
  localparam int MAX_EXPONENT_DEF = 63;

  // Field widths
  localparam int EXP_W   = 6;
  localparam int TDATA_W = 8;

  // Partial product selector: low*low, low*high, high*high
  typedef enum logic [1:0] {
    MS_LL,
    MS_LH,
    MS_HH
  } mul_sel_t;

  // Controller to datapath commands
  typedef struct packed {
    logic     load;
    logic     mul_en;
    mul_sel_t mul_sel;
    logic     acc_en;
    mul_sel_t acc_sel;
    logic     fold_en;
    logic     reduce_en;
    logic     update_en;
    logic     publish;
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic run_test;
    logic last_iter;
  } stat_t;

endpackage

`default_nettype wire

### src/lucas_lehmer_mersenne_test_unit.sv
// Lucas-Lehmer test of 2^p-1, one exponent at a time.
// Exponents 3 <= p <= MAX_EXPONENT run p-2 squarings; other exponents skip straight
// to the result, prime only for p=2. Each squaring uses the shared
// half-width multiplier (three partial products) followed by fold, reduce, update.
// A new exponent is accepted only when idle, after the last result is published.
// Reset: rst_n synchronous, active low; clears the controller and output valid.
`default_nettype none
`include "lucas_lehmer_mersenne_test_unit_assert.svh"

module lucas_lehmer_mersenne_test_unit #(
  parameter int MAX_EXPONENT = llmt_pkg::MAX_EXPONENT_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_tvalid,
  output logic                              in_tready,
  // [5:0] exponent, [7:6] zero
  input  wire logic [llmt_pkg::TDATA_W-1:0] in_tdata,
  output logic                              out_tvalid,
  input  wire logic                         out_tready,
  // [0] prime flag, [6:1] tested_exponent, [7] zero
  output logic [llmt_pkg::TDATA_W-1:0]      out_tdata
);

  llmt_pkg::cmd_t  cmd;
  llmt_pkg::stat_t stat;
  logic                       prime_flag;
  logic [llmt_pkg::EXP_W-1:0] tested_exponent;

  llmt_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .stat       (stat),
    .cmd        (cmd)
  );

  llmt_datapath #(
    .MAX_EXPONENT (MAX_EXPONENT)
  ) u_datapath (
    .clk                 (clk),
    .in_exponent         (in_tdata[llmt_pkg::EXP_W-1:0]),
    .cmd                 (cmd),
    .stat                (stat),
    .out_prime_flag      (prime_flag),
    .out_tested_exponent (tested_exponent)
  );

  // Pack the result word
  assign out_tdata = {1'b0, tested_exponent, prime_flag};

  // Checks
  `LLMT_ASSERT_NEXT(a_busy_after_accept, in_tvalid && in_tready, !in_tready, "accepted while busy")
  `LLMT_ASSERT_NEXT(a_publish_valid, cmd.publish, out_tvalid, "published result not valid")
  `LLMT_ASSERT_NOW(a_idle_no_work, in_tready, !cmd.mul_en && !cmd.update_en, "work while idle")
  `LLMT_ASSERT_NEXT(a_exp_two_prime, cmd.publish, (out_tdata[6:1] != 6'd2) || out_tdata[0], "p=2 not prime")

endmodule

`default_nettype wire

### src/llmt_datapath.sv
`default_nettype none

module llmt_datapath #(
  parameter int MAX_EXPONENT = llmt_pkg::MAX_EXPONENT_DEF
) (
  input  wire logic                       clk,
  input  wire logic [llmt_pkg::EXP_W-1:0] in_exponent,
  input  wire llmt_pkg::cmd_t             cmd,
  output llmt_pkg::stat_t                 stat,
  output logic                            out_prime_flag,
  output logic [llmt_pkg::EXP_W-1:0]      out_tested_exponent
);

  localparam int W     = MAX_EXPONENT;
  localparam int H     = (W + 1) / 2;
  localparam int ACC_W = 4 * H;
  localparam int EW    = llmt_pkg::EXP_W;
  localparam logic [EW:0] MAX_E = (EW + 1)'(MAX_EXPONENT);

  logic [EW-1:0]    exp_r;
  logic [EW-1:0]    iter_r;
  logic [W-1:0]     mask_r;
  logic [W-1:0]     s_r;
  logic [2*H-1:0]   prod_r;
  logic [ACC_W-1:0] acc_r;
  logic [W:0]       fold_r;
  logic [W-1:0]     red_r;
  logic             prime_r;
  logic [EW-1:0]    out_exp_r;

  logic [W-1:0]     mask_nxt;
  logic [2*H-1:0]   s_pad;
  logic [H-1:0]     op_a;
  logic [H-1:0]     op_b;
  logic [ACC_W-1:0] term;
  logic [ACC_W-1:0] acc_base;
  logic [ACC_W-1:0] hi_full;
  logic [W-1:0]     lo;
  logic             run_test;

  // Build the modulus mask 2^p - 1 from the incoming exponent
  always_comb begin
    for (int i = 0; i < W; i++) begin
      mask_nxt[i] = (i < int'(in_exponent));
    end
  end

  // Select the halves of the residue for the shared multiplier
  assign s_pad = (2 * H)'(s_r);
  always_comb begin
    case (cmd.mul_sel)
      llmt_pkg::MS_LL: begin
        op_a = s_pad[H-1:0];
        op_b = s_pad[H-1:0];
      end
      llmt_pkg::MS_LH: begin
        op_a = s_pad[H-1:0];
        op_b = s_pad[2*H-1:H];
      end
      llmt_pkg::MS_HH: begin
        op_a = s_pad[2*H-1:H];
        op_b = s_pad[2*H-1:H];
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  // Weight the partial product: cross term counts twice
  always_comb begin
    case (cmd.acc_sel)
      llmt_pkg::MS_LL: term = ACC_W'(prod_r);
      llmt_pkg::MS_LH: term = ACC_W'(prod_r) << (H + 1);
      llmt_pkg::MS_HH: term = ACC_W'(prod_r) << (2 * H);
      default:         term = '0;
    endcase
  end
  assign acc_base = (cmd.acc_sel == llmt_pkg::MS_LL) ? '0 : acc_r;

  // Mersenne fold of the square: low p bits plus the bits above
  assign hi_full = acc_r >> exp_r;
  assign lo      = acc_r[W-1:0] & mask_r;

  // Classify the exponent and detect the final squaring
  assign run_test       = (exp_r >= EW'(3)) && ({1'b0, exp_r} <= MAX_E);
  assign stat.run_test  = run_test;
  assign stat.last_iter = (({1'b0, iter_r} + (EW + 1)'(3)) == {1'b0, exp_r});

  // Datapath registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      exp_r  <= in_exponent;
      mask_r <= mask_nxt;
      iter_r <= '0;
      s_r    <= W'(4);
    end
    if (cmd.mul_en) begin
      prod_r <= op_a * op_b;
    end
    if (cmd.acc_en) begin
      acc_r <= acc_base + term;
    end
    if (cmd.fold_en) begin
      fold_r <= {1'b0, lo} + {1'b0, hi_full[W-1:0]};
    end
    if (cmd.reduce_en) begin
      // sum is at most 2M, so one subtract leaves [0, M]
      if (fold_r >= {1'b0, mask_r}) begin
        red_r <= W'(fold_r - {1'b0, mask_r});
      end else begin
        red_r <= fold_r[W-1:0];
      end
    end
    if (cmd.update_en) begin
      // subtract two modulo M; a value of M itself gives M-2 as well
      if (red_r >= W'(2)) begin
        s_r <= red_r - W'(2);
      end else begin
        s_r <= red_r + mask_r - W'(2);
      end
      iter_r <= iter_r + EW'(1);
    end
    if (cmd.publish) begin
      prime_r   <= run_test ? (s_r == '0) : (exp_r == EW'(2));
      out_exp_r <= exp_r;
    end
  end

  assign out_prime_flag      = prime_r;
  assign out_tested_exponent = out_exp_r;

endmodule

`default_nettype wire

### src/llmt_ctrl.sv
`default_nettype none

module llmt_ctrl (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_tvalid,
  output logic                 in_tready,
  output logic                 out_tvalid,
  input  wire logic            out_tready,
  input  wire llmt_pkg::stat_t stat,
  output llmt_pkg::cmd_t       cmd
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHECK,
    S_MUL0,
    S_MUL1,
    S_MUL2,
    S_ACC2,
    S_FOLD,
    S_REDUCE,
    S_UPDATE,
    S_FINISH
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   out_valid_r;
  logic   out_valid_nxt;
  logic   slot_free;

  assign slot_free = !out_valid_r || out_tready;

  // Decode commands and next state
  always_comb begin
    cmd           = '0;
    cmd.mul_sel   = llmt_pkg::MS_LL;
    cmd.acc_sel   = llmt_pkg::MS_LL;
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_tready;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        state_nxt = stat.run_test ? S_MUL0 : S_FINISH;
      end
      S_MUL0: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = llmt_pkg::MS_LL;
        state_nxt   = S_MUL1;
      end
      S_MUL1: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = llmt_pkg::MS_LH;
        cmd.acc_en  = 1'b1;
        cmd.acc_sel = llmt_pkg::MS_LL;
        state_nxt   = S_MUL2;
      end
      S_MUL2: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = llmt_pkg::MS_HH;
        cmd.acc_en  = 1'b1;
        cmd.acc_sel = llmt_pkg::MS_LH;
        state_nxt   = S_ACC2;
      end
      S_ACC2: begin
        cmd.acc_en  = 1'b1;
        cmd.acc_sel = llmt_pkg::MS_HH;
        state_nxt   = S_FOLD;
      end
      S_FOLD: begin
        cmd.fold_en = 1'b1;
        state_nxt   = S_REDUCE;
      end
      S_REDUCE: begin
        cmd.reduce_en = 1'b1;
        state_nxt     = S_UPDATE;
      end
      S_UPDATE: begin
        cmd.update_en = 1'b1;
        state_nxt     = stat.last_iter ? S_FINISH : S_MUL0;
      end
      S_FINISH: begin
        // hold until the output register is free
        if (slot_free) begin
          cmd.publish   = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State and output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;

endmodule

`default_nettype wire
